// File: design/binary_gps_log_deframer_crc32_assert.svh
// ----------------------------------------------------------------------------
// binary_gps_log_deframer_crc32_assert.svh
// Assertion macros shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_GPS_LOG_DEFRAMER_CRC32_ASSERT_SVH
`define BINARY_GPS_LOG_DEFRAMER_CRC32_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define BGLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on every clock edge, reset included.
`define BGLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: design/bgld_pkg.sv
// ----------------------------------------------------------------------------
// bgld_pkg
// Types, constants and the CRC-32 byte update for the binary log deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package bgld_pkg;

  // Input beat kinds
  localparam logic IN_BYTE  = 1'b0;
  localparam logic IN_ERROR = 1'b1;

  // Result beat kinds
  localparam logic OUT_BODY = 1'b0;
  localparam logic OUT_END  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_CRC_ERR  = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_e;

  // Framing constants
  localparam logic [7:0]  SYNC_A       = 8'hAA;
  localparam logic [7:0]  SYNC_B       = 8'h44;
  localparam logic [7:0]  SYNC_C       = 8'h12;
  localparam logic [16:0] SYNC_BYTES   = 17'd3;
  localparam logic [16:0] HEADER_BYTES = 17'd28;
  localparam logic [16:0] CRC_BYTES    = 17'd4;
  localparam logic [16:0] ID_LO_POS    = 17'd4;
  localparam logic [16:0] ID_HI_POS    = 17'd5;
  localparam logic [16:0] LEN_LO_POS   = 17'd8;
  localparam logic [16:0] LEN_HI_POS   = 17'd9;
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [16:0] MAX_FRAME_RESET = 17'd2048;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        out_kind;
    logic [1:0]  status;
    logic [7:0]  body_byte;
    logic [15:0] body_index;
    logic [15:0] message_id;
    logic [15:0] message_length;
  } out_t;

  // Result handed from the parser to the output stage
  typedef struct packed {
    logic valid;
    out_t beat;
  } res_t;

  // Reflected CRC-32, one byte per call
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] t;
    t = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      if (t[0]) begin
        t = (t >> 1) ^ CRC_POLY;
      end else begin
        t = t >> 1;
      end
    end
    return {8'd0, crc[31:8]} ^ t;
  endfunction

endpackage

`default_nettype wire

// File: design/bgld_parser.sv
// ----------------------------------------------------------------------------
// bgld_parser
// Frame state: sync hunt, header capture, length check, body forwarding and CRC check.
// ----------------------------------------------------------------------------
`default_nettype none

module bgld_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire bgld_pkg::in_t beat_i,
  input  wire logic          cfg_we_i,
  input  wire logic [16:0]   cfg_wdata_i,
  output bgld_pkg::res_t     res_o
);

  logic [16:0] pos_q, pos_d;
  logic [15:0] id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [31:0] crc_q, crc_d;
  logic [16:0] max_q;

  logic [31:0] crc_next;
  logic [7:0]  want;
  logic [17:0] pos_inc;
  logic [17:0] body_end;
  logic [17:0] frame_end;
  logic        too_long;
  logic [16:0] body_off;

  // Shared byte-wide terms
  assign crc_next  = bgld_pkg::crc_update(crc_q, beat_i.rx_byte);
  assign want      = (pos_q == 17'd0) ? bgld_pkg::SYNC_A :
                     (pos_q == 17'd1) ? bgld_pkg::SYNC_B : bgld_pkg::SYNC_C;
  assign pos_inc   = {1'b0, pos_q} + 18'd1;
  assign body_end  = {1'b0, bgld_pkg::HEADER_BYTES} + {2'b00, len_q};
  assign frame_end = body_end + {1'b0, bgld_pkg::CRC_BYTES};
  assign too_long  = frame_end > {1'b0, max_q};
  assign body_off  = pos_q - bgld_pkg::HEADER_BYTES;

  // Advance the frame state for one accepted beat
  always_comb begin
    pos_d = pos_q;
    id_d  = id_q;
    len_d = len_q;
    crc_d = crc_q;
    res_o = '0;
    res_o.beat.message_id     = id_q;
    res_o.beat.message_length = len_q;
    if (accept_i) begin
      if (beat_i.kind == bgld_pkg::IN_ERROR) begin
        pos_d = '0;
        crc_d = '0;
        id_d  = '0;
        len_d = '0;
      end else if (pos_q < bgld_pkg::SYNC_BYTES) begin
        if (beat_i.rx_byte == want) begin
          crc_d = crc_next;
          pos_d = pos_inc[16:0];
        end else begin
          pos_d = '0;
          crc_d = '0;
        end
      end else if (pos_q < bgld_pkg::HEADER_BYTES) begin
        crc_d = crc_next;
        pos_d = pos_inc[16:0];
        if (pos_q == bgld_pkg::ID_LO_POS)  id_d[7:0]   = beat_i.rx_byte;
        if (pos_q == bgld_pkg::ID_HI_POS)  id_d[15:8]  = beat_i.rx_byte;
        if (pos_q == bgld_pkg::LEN_LO_POS) len_d[7:0]  = beat_i.rx_byte;
        if (pos_q == bgld_pkg::LEN_HI_POS) len_d[15:8] = beat_i.rx_byte;
        // Drop an oversized frame as soon as the header is in
        if (pos_inc[16:0] == bgld_pkg::HEADER_BYTES && too_long) begin
          res_o.valid         = 1'b1;
          res_o.beat.out_kind = bgld_pkg::OUT_END;
          res_o.beat.status   = bgld_pkg::STATUS_TOO_LONG;
          pos_d = '0;
          crc_d = '0;
        end
      end else if ({1'b0, pos_q} < body_end) begin
        crc_d = crc_next;
        pos_d = pos_inc[16:0];
        res_o.valid           = 1'b1;
        res_o.beat.out_kind   = bgld_pkg::OUT_BODY;
        res_o.beat.status     = bgld_pkg::STATUS_GOOD;
        res_o.beat.body_byte  = beat_i.rx_byte;
        res_o.beat.body_index = body_off[15:0];
      end else if (pos_inc >= frame_end) begin
        // Last CRC byte: a zero residue means the frame is good
        res_o.valid         = 1'b1;
        res_o.beat.out_kind = bgld_pkg::OUT_END;
        res_o.beat.status   = (crc_next != 32'd0) ? bgld_pkg::STATUS_CRC_ERR
                                                  : bgld_pkg::STATUS_GOOD;
        pos_d = '0;
        crc_d = '0;
      end else begin
        crc_d = crc_next;
        pos_d = pos_inc[16:0];
      end
    end
  end

  // Hold the frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      id_q  <= '0;
      len_q <= '0;
      crc_q <= '0;
    end else begin
      pos_q <= pos_d;
      id_q  <= id_d;
      len_q <= len_d;
      crc_q <= crc_d;
    end
  end

  // Frame length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= bgld_pkg::MAX_FRAME_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: design/binary_gps_log_deframer_crc32.sv
// A result beat is registered; it is shown in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle unless stalled; the CRC byte update is combinational.
// Input is stalled only while a result beat waits in the output register and out_ready_i is low.
// Reset (rst_ni low, asynchronous) returns the parser to sync hunt, clears CRC, id and length,
// sets the frame limit to 2048 bytes and empties the output register.
// ----------------------------------------------------------------------------
// binary_gps_log_deframer_crc32
// Byte-serial deframer for binary GPS logs with reflected CRC-32 check.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_gps_log_deframer_crc32 (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bgld_pkg::in_t in_beat_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bgld_pkg::out_t     out_beat_o,
  input  wire logic          cfg_we_i,
  input  wire logic [16:0]   cfg_wdata_i
);

  `include "binary_gps_log_deframer_crc32_assert.svh"

  logic           in_fire;
  bgld_pkg::res_t res;
  logic           out_valid_q, out_valid_d;
  bgld_pkg::out_t out_q;

  // Take a beat whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  bgld_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .beat_i      (in_beat_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result beat
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_q <= res.beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // Checks
  `BGLD_ASSERT(a_res_needs_accept, res.valid |-> in_fire,
               "result produced without an accepted beat")
  `BGLD_ASSERT(a_no_overwrite, (out_valid_q && !out_ready_i) |-> !res.valid,
               "pending result overwritten")
  `BGLD_ASSERT(a_body_status, (out_valid_o && out_beat_o.out_kind == bgld_pkg::OUT_BODY)
               |-> (out_beat_o.status == bgld_pkg::STATUS_GOOD),
               "body beat carries a status")
  `BGLD_ASSERT(a_body_index, (out_valid_o && out_beat_o.out_kind == bgld_pkg::OUT_BODY)
               |-> (out_beat_o.body_index < out_beat_o.message_length),
               "body index beyond message length")
  `BGLD_ASSERT(a_error_no_result, (in_fire && in_beat_i.kind == bgld_pkg::IN_ERROR)
               |-> !res.valid,
               "read error beat produced a result")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary GPS log deframer. A table of directed
// frames (reset limit, empty bodies, exact limit boundaries, CRC errors,
// frames too long, limits below the header size, the longest legal body cut
// short by a read error, false sync) runs first, then random frames, broken
// frames and noise under several frame limits. Every result beat is compared
// against an in-bench deframer model.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 780;
  localparam int SETTLE_CYCLES = 3;

  typedef enum logic [2:0] {
    SEQ_ERROR,
    SEQ_NOISE,
    SEQ_FALSE_SYNC,
    SEQ_GOOD,
    SEQ_BAD_CRC,
    SEQ_TOO_LONG,
    SEQ_ABORT
  } seq_e;

  typedef struct packed {
    logic              write_limit;
    logic [16:0]       limit;
    seq_e              seq;
    logic [15:0]       id;
    logic [15:0]       len;
    logic              typed;
    bgld_pkg::status_e status;
  } plan_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  bgld_pkg::in_t  in_beat_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  bgld_pkg::out_t out_beat_o;
  logic           cfg_we_i = 1'b0;
  logic [16:0]    cfg_wdata_i = '0;

  // Deframer model state
  logic [16:0]    frame_pos;
  logic [15:0]    hdr_id;
  logic [15:0]    hdr_len;
  logic [31:0]    run_crc;
  logic [16:0]    frame_limit;
  bgld_pkg::out_t deframed_q[$];

  int                fail_count = 0;
  int                beats_sent = 0;
  int                burst_left = 0;
  int                body_seen = 0;
  int                good_seen = 0;
  int                crc_err_seen = 0;
  int                too_long_seen = 0;
  int                ends_seen = 0;
  bgld_pkg::status_e end_status_seen = bgld_pkg::STATUS_GOOD;
  logic [31:0]       cycle_count = '0;

  // Directed frames: optional limit write, sequence, header fields, typed end status
  plan_row_t plan [16] = '{
    '{1'b0, 17'd0,     SEQ_ERROR,      16'h0000, 16'd0,     1'b0, bgld_pkg::STATUS_GOOD},
    '{1'b0, 17'd0,     SEQ_GOOD,       16'h0000, 16'd0,     1'b1, bgld_pkg::STATUS_GOOD},
    '{1'b0, 17'd0,     SEQ_GOOD,       16'hFFFF, 16'd5,     1'b1, bgld_pkg::STATUS_GOOD},
    '{1'b0, 17'd0,     SEQ_BAD_CRC,    16'h1234, 16'd3,     1'b1, bgld_pkg::STATUS_CRC_ERR},
    '{1'b0, 17'd0,     SEQ_TOO_LONG,   16'h00FF, 16'd2017,  1'b1, bgld_pkg::STATUS_TOO_LONG},
    '{1'b0, 17'd0,     SEQ_FALSE_SYNC, 16'h0000, 16'd0,     1'b0, bgld_pkg::STATUS_GOOD},
    '{1'b0, 17'd0,     SEQ_ABORT,      16'h5A5A, 16'd10,    1'b0, bgld_pkg::STATUS_GOOD},
    '{1'b1, 17'd100,   SEQ_GOOD,       16'hFF00, 16'd68,    1'b1, bgld_pkg::STATUS_GOOD},
    '{1'b0, 17'd0,     SEQ_TOO_LONG,   16'h0102, 16'd69,    1'b1, bgld_pkg::STATUS_TOO_LONG},
    '{1'b1, 17'd32,    SEQ_GOOD,       16'h8001, 16'd0,     1'b1, bgld_pkg::STATUS_GOOD},
    '{1'b0, 17'd0,     SEQ_TOO_LONG,   16'h0102, 16'd1,     1'b1, bgld_pkg::STATUS_TOO_LONG},
    '{1'b1, 17'd0,     SEQ_TOO_LONG,   16'h7FFF, 16'd0,     1'b1, bgld_pkg::STATUS_TOO_LONG},
    '{1'b1, 17'd31,    SEQ_TOO_LONG,   16'hABCD, 16'd0,     1'b1, bgld_pkg::STATUS_TOO_LONG},
    '{1'b1, 17'd65567, SEQ_ABORT,      16'hA55A, 16'd65535, 1'b0, bgld_pkg::STATUS_GOOD},
    '{1'b1, 17'd65566, SEQ_TOO_LONG,   16'h55AA, 16'd65535, 1'b1, bgld_pkg::STATUS_TOO_LONG},
    '{1'b1, 17'h1FFFF, SEQ_BAD_CRC,    16'hC3C3, 16'd40,    1'b1, bgld_pkg::STATUS_CRC_ERR}
  };

  binary_gps_log_deframer_crc32 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Reflected CRC-32, one byte, no final inversion
  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] t;
    t = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      t = t[0] ? ((t >> 1) ^ 32'hEDB88320) : (t >> 1);
    end
    return (crc >> 8) ^ t;
  endfunction

  function automatic void push_result(input logic kind, input bgld_pkg::status_e st,
                                      input logic [7:0] b, input logic [15:0] idx);
    bgld_pkg::out_t r;
    r.out_kind       = kind;
    r.status         = st;
    r.body_byte      = b;
    r.body_index     = idx;
    r.message_id     = hdr_id;
    r.message_length = hdr_len;
    deframed_q.push_back(r);
  endfunction

  // Advance the deframer model by one accepted beat
  function automatic void deframe_byte(input bgld_pkg::in_t beat);
    int unsigned pos;
    int unsigned frame_total;
    logic [7:0]  b;
    logic [7:0]  want;
    if (beat.kind == bgld_pkg::IN_ERROR) begin
      hdr_id    = '0;
      hdr_len   = '0;
      frame_pos = '0;
      run_crc   = '0;
      return;
    end
    b   = beat.rx_byte;
    pos = frame_pos;
    // Hunt for the three sync bytes; a mismatch restarts the hunt
    if (pos < bgld_pkg::SYNC_BYTES) begin
      want = (pos == 0) ? bgld_pkg::SYNC_A : (pos == 1) ? bgld_pkg::SYNC_B : bgld_pkg::SYNC_C;
      if (b == want) begin
        run_crc   = crc32_step(run_crc, b);
        frame_pos = 17'(pos + 1);
      end else begin
        frame_pos = '0;
        run_crc   = '0;
      end
      return;
    end
    run_crc = crc32_step(run_crc, b);
    // Capture header fields, check the frame length once the header is in
    if (pos < bgld_pkg::HEADER_BYTES) begin
      case (pos)
        bgld_pkg::ID_LO_POS:  hdr_id[7:0]   = b;
        bgld_pkg::ID_HI_POS:  hdr_id[15:8]  = b;
        bgld_pkg::LEN_LO_POS: hdr_len[7:0]  = b;
        bgld_pkg::LEN_HI_POS: hdr_len[15:8] = b;
        default: ;
      endcase
      pos++;
      frame_pos   = 17'(pos);
      frame_total = bgld_pkg::HEADER_BYTES + hdr_len + bgld_pkg::CRC_BYTES;
      if (pos == bgld_pkg::HEADER_BYTES && frame_total > frame_limit) begin
        push_result(bgld_pkg::OUT_END, bgld_pkg::STATUS_TOO_LONG, 8'd0, 16'd0);
        frame_pos = '0;
        run_crc   = '0;
      end
      return;
    end
    // Forward body bytes, then close the frame after the CRC bytes
    if (pos < bgld_pkg::HEADER_BYTES + hdr_len) begin
      push_result(bgld_pkg::OUT_BODY, bgld_pkg::STATUS_GOOD, b,
                  16'(pos - bgld_pkg::HEADER_BYTES));
      frame_pos = 17'(pos + 1);
      return;
    end
    pos++;
    frame_total = bgld_pkg::HEADER_BYTES + hdr_len + bgld_pkg::CRC_BYTES;
    if (pos >= frame_total) begin
      push_result(bgld_pkg::OUT_END,
                  (run_crc != 0) ? bgld_pkg::STATUS_CRC_ERR : bgld_pkg::STATUS_GOOD,
                  8'd0, 16'd0);
      frame_pos = '0;
      run_crc   = '0;
    end else begin
      frame_pos = 17'(pos);
    end
  endfunction

  // Drive one beat in bursts with random gaps, hold it until accepted
  task automatic put_beat(input bgld_pkg::in_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    deframe_byte(beat);
    beats_sent++;
  endtask

  // Hold the sender until every expected beat is out and the block is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [16:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    frame_limit = value;
  endtask

  // Send a frame, a broken frame or noise
  task automatic send_sequence(input seq_e seq, input logic [15:0] id, input int len);
    logic [7:0]  fake [10];
    logic [31:0] crc;
    logic [7:0]  b;
    int          total;
    int          stop;
    int          flip_at;
    int          hdr;
    fake = '{bgld_pkg::SYNC_A, bgld_pkg::SYNC_B, bgld_pkg::SYNC_A, bgld_pkg::SYNC_B,
             bgld_pkg::SYNC_C, bgld_pkg::SYNC_A, bgld_pkg::SYNC_B, 8'h13,
             bgld_pkg::SYNC_A, bgld_pkg::SYNC_A};
    hdr  = int'(bgld_pkg::HEADER_BYTES);
    case (seq)
      SEQ_ERROR: begin
        put_beat(bgld_pkg::in_t'({bgld_pkg::IN_ERROR, 8'($urandom_range(0, 255))}));
      end
      SEQ_NOISE: begin
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 9))
            0: put_beat(bgld_pkg::in_t'({bgld_pkg::IN_ERROR, 8'($urandom_range(0, 255))}));
            1: put_beat(bgld_pkg::in_t'({bgld_pkg::IN_BYTE, bgld_pkg::SYNC_A}));
            2: put_beat(bgld_pkg::in_t'({bgld_pkg::IN_BYTE, bgld_pkg::SYNC_B}));
            3: put_beat(bgld_pkg::in_t'({bgld_pkg::IN_BYTE, bgld_pkg::SYNC_C}));
            default: put_beat(bgld_pkg::in_t'({bgld_pkg::IN_BYTE,
                                               8'($urandom_range(0, 255))}));
          endcase
        end
      end
      SEQ_FALSE_SYNC: begin
        foreach (fake[i]) put_beat(bgld_pkg::in_t'({bgld_pkg::IN_BYTE, fake[i]}));
      end
      default: begin
        total   = hdr + len + int'(bgld_pkg::CRC_BYTES);
        stop    = total;
        flip_at = -1;
        // Cut an oversized frame short; the tail is only rescanned for sync
        if (seq == SEQ_TOO_LONG) stop = hdr + ((len < 40) ? len : 40);
        // Abort a frame with a read error: a short one anywhere, a long one within its first 40 body bytes
        if (seq == SEQ_ABORT) begin
          stop = (total <= hdr + 41) ? $urandom_range(1, total - 1)
                                     : $urandom_range(hdr + 1, hdr + 40);
        end
        if (seq == SEQ_BAD_CRC) flip_at = $urandom_range(hdr, total - 1);
        crc = '0;
        for (int i = 0; i < stop; i++) begin
          if (i < hdr + len) begin
            case (i)
              0:                    b = bgld_pkg::SYNC_A;
              1:                    b = bgld_pkg::SYNC_B;
              2:                    b = bgld_pkg::SYNC_C;
              bgld_pkg::ID_LO_POS:  b = id[7:0];
              bgld_pkg::ID_HI_POS:  b = id[15:8];
              bgld_pkg::LEN_LO_POS: b = len[7:0];
              bgld_pkg::LEN_HI_POS: b = len[15:8];
              default:              b = 8'($urandom_range(0, 255));
            endcase
            crc = crc32_step(crc, b);
          end else begin
            b = crc[8 * (i - hdr - len) +: 8];
          end
          if (i == flip_at) b = b ^ (8'd1 << $urandom_range(0, 7));
          put_beat(bgld_pkg::in_t'({bgld_pkg::IN_BYTE, b}));
        end
        if (seq == SEQ_ABORT) begin
          put_beat(bgld_pkg::in_t'({bgld_pkg::IN_ERROR, 8'($urandom_range(0, 255))}));
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver stall pattern, switching style as cycle_count[10:9] changes
  always @(posedge clk_i) begin
    case (cycle_count[10:9])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready_i <= (cycle_count[2:0] != 3'd5) && (cycle_count[4:3] != 2'd2);
      default: out_ready_i <= 1'($urandom_range(0, 1));
    endcase
    cycle_count <= cycle_count + 1;
  end

  // Compare each result beat with the oldest predicted one
  always @(posedge clk_i) begin
    bgld_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (deframed_q.size() == 0) begin
        $error("result beat with nothing expected: 0x%0h", out_beat_o);
        fail_count++;
      end else begin
        want = deframed_q.pop_front();
        check_field("out_kind", want.out_kind, out_beat_o.out_kind);
        check_field("status", want.status, out_beat_o.status);
        check_field("body_byte", want.body_byte, out_beat_o.body_byte);
        check_field("body_index", want.body_index, out_beat_o.body_index);
        check_field("message_id", want.message_id, out_beat_o.message_id);
        check_field("message_length", want.message_length, out_beat_o.message_length);
      end
      if (out_beat_o.out_kind == bgld_pkg::OUT_END) begin
        ends_seen++;
        end_status_seen = bgld_pkg::status_e'(out_beat_o.status);
        case (bgld_pkg::status_e'(out_beat_o.status))
          bgld_pkg::STATUS_GOOD:    good_seen++;
          bgld_pkg::STATUS_CRC_ERR: crc_err_seen++;
          default:                  too_long_seen++;
        endcase
      end else begin
        body_seen++;
      end
    end
  end

  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [16:0] limits [6];
    int          ends_before;
    int          base;
    int          pick;
    int          len;
    int          lo;
    seq_e        seq;

    frame_pos   = '0;
    hdr_id      = '0;
    hdr_len     = '0;
    run_crc     = '0;
    frame_limit = bgld_pkg::MAX_FRAME_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames, typed end status checked once the frame has drained
    foreach (plan[i]) begin
      if (plan[i].write_limit) set_limit(plan[i].limit);
      ends_before = ends_seen;
      send_sequence(plan[i].seq, plan[i].id, int'(plan[i].len));
      if (plan[i].typed) begin
        settle();
        if (ends_seen == ends_before || end_status_seen != plan[i].status) begin
          $error("status: expected %s, got %s after %0d frame ends",
                 plan[i].status.name(), end_status_seen.name(), ends_seen - ends_before);
          fail_count++;
        end
      end
    end

    // Random traffic, one frame limit per phase
    limits = '{17'd200, 17'd32, 17'd65567, 17'd0, 17'd1000, 17'h1FFFF};
    base = beats_sent;
    for (int ph = 0; ph < 6; ph++) begin
      set_limit(limits[ph]);
      while (beats_sent < base + (ph + 1) * RANDOM_BEATS / 6) begin
        pick = $urandom_range(0, 49);
        len  = (pick < 40) ? $urandom_range(0, 24) :
               (pick < 49) ? $urandom_range(25, 200) : $urandom_range(201, 600);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          seq = SEQ_GOOD;
        end else if (pick < 67) begin
          seq = SEQ_BAD_CRC;
        end else if (pick < 77) begin
          lo = int'(frame_limit) - 31;
          if (lo < 0) lo = 0;
          if (lo > 65535) begin
            seq = SEQ_GOOD;
          end else begin
            seq = SEQ_TOO_LONG;
            len = lo + $urandom_range(0, 50);
            if (len > 65535) len = 65535;
          end
        end else if (pick < 87) begin
          seq = SEQ_ABORT;
        end else begin
          seq = SEQ_NOISE;
          len = $urandom_range(1, 12);
        end
        send_sequence(seq, 16'($urandom_range(0, 65535)), len);
      end
    end

    settle();
    $display("covered %0d input beats over frame limits 0 to 131071, read errors and noise",
             beats_sent);
    $display("seen %0d body beats, %0d good, %0d CRC error, %0d too long frame ends",
             body_seen, good_seen, crc_err_seen, too_long_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
